FILE: rtl/bf3_pkg.sv
// Shared constants and types for the 3x3 box filter row segment block.
package bf3_pkg;

   // Segment geometry
   localparam int ROW_WIDTH = 64;
   localparam int HDR_LEN   = 4;
   localparam int ROW_LEN   = ROW_WIDTH + 2;
   localparam int COL_W     = $clog2(ROW_LEN);

   // Data widths
   localparam int PIX_W  = 8;
   localparam int CSUM_W = 10;
   localparam int SUM_W  = 12;

   // Largest window sum nine full-scale pixels can give
   localparam int MAX_SUM = 9 * 255;

   // Divide by nine: multiply by ceil(2^16 / 9) and drop 16 bits.
   // Exact for every sum below 2^SUM_W.
   localparam int DIV_SHIFT = 16;
   localparam int DIV_MUL   = ((1 << DIV_SHIFT) + 8) / 9;
   localparam int DIV_W     = 13;
   localparam int PROD_W    = SUM_W + DIV_W;

   // Where the next input word falls in the segment
   typedef enum logic [1:0] {
      PH_HDR,
      PH_ROW0,
      PH_ROW1,
      PH_ROW2
   } phase_type;

   // Write port of the column sum memory
   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  addr;
      logic [CSUM_W-1:0] data;
   } colsum_wr_type;

endpackage

FILE: rtl/bf3_colsum_ram.sv
// Column sum memory: one write port, one registered read port.
module bf3_colsum_ram
   import bf3_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   output logic [CSUM_W-1:0] rd_data,
   input  colsum_wr_type     wr
);

   logic [CSUM_W-1:0] mem [ROW_LEN];
   logic [CSUM_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/box_filter_3x3_row_segment.sv
// 3x3 box filter over a header plus three rows: top level.
// A result word goes through the stage 1, stage 2 and output registers to the rsp_ port.
// Throughput: one word per cycle while rsp_stall is low; set by the one read-modify-write
// of the column sum memory per word: read at accept, written back when it leaves stage 1.
// Reset: position returns to header byte 0, pipeline emptied, prior column totals zeroed.
// The column sum memory is not cleared; row 0 writes every entry before it is read.
module box_filter_3x3_row_segment
   import bf3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_pixel_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic             rsp_is_header,
   output logic             rsp_last
);

   localparam logic [COL_W-1:0] HDR_END = COL_W'(HDR_LEN - 1);
   localparam logic [COL_W-1:0] ROW_END = COL_W'(ROW_LEN - 1);
   localparam logic [COL_W-1:0] WIN_COL = COL_W'(2);

   // position in segment
   phase_type        phase_ff, phase_in;
   logic [COL_W-1:0] col_ff, col_in;

   // stage 1: word with its memory read under way
   logic             s1_v_ff;
   phase_type        s1_phase_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;

   // stage 2: window sum or header word
   logic             s2_v_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   logic [PIX_W-1:0] s2_pix_ff;
   logic             s2_hdr_ff;
   logic             s2_last_ff;

   // output register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_hdr_ff;
   logic             rsp_last_ff;

   // totals of the two previous columns of row 2
   logic [CSUM_W-1:0] tot_a_ff;
   logic [CSUM_W-1:0] tot_b_ff;

   logic              out_en, s2_en, s1_en, accept;
   logic [CSUM_W-1:0] rd_data;
   logic [CSUM_W-1:0] col_total;
   logic [SUM_W-1:0]  win_sum;
   logic [PROD_W-1:0] prod;
   colsum_wr_type     wr;

   // stage enables, each stage moves when the one after it has room
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s2_en     = !s2_v_ff || out_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   // position sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         col_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      col_in   = col_ff;
      if (accept) begin
         col_in = col_ff + COL_W'(1);
         unique case (phase_ff)
            PH_HDR: begin
               if (col_ff == HDR_END) begin
                  phase_in = PH_ROW0;
                  col_in   = '0;
               end
            end
            PH_ROW0: begin
               if (col_ff == ROW_END) begin
                  phase_in = PH_ROW1;
                  col_in   = '0;
               end
            end
            PH_ROW1: begin
               if (col_ff == ROW_END) begin
                  phase_in = PH_ROW2;
                  col_in   = '0;
               end
            end
            PH_ROW2: begin
               if (col_ff == ROW_END) begin
                  phase_in = PH_HDR;
                  col_in   = '0;
               end
            end
            default: begin
               phase_in = PH_HDR;
               col_in   = '0;
            end
         endcase
      end
   end

   // column sum memory, read at accept
   bf3_colsum_ram u_colsum (
      .clock   (clock),
      .rd_en   (s1_en),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_phase_ff <= phase_ff;
         s1_col_ff   <= col_ff;
         s1_pix_ff   <= req_pixel_in;
         s1_emit_ff  <= (phase_ff == PH_HDR) ||
                        ((phase_ff == PH_ROW2) && (col_ff >= WIN_COL));
         s1_last_ff  <= (phase_ff == PH_ROW2) && (col_ff == ROW_END);
      end
   end

   // read-modify-write of the column sum, window sum for row 2
   assign col_total = rd_data + CSUM_W'(s1_pix_ff);
   assign win_sum   = SUM_W'(col_total) + SUM_W'(tot_a_ff) + SUM_W'(tot_b_ff);

   always_comb begin
      wr.en   = s2_en && s1_v_ff &&
                ((s1_phase_ff == PH_ROW0) || (s1_phase_ff == PH_ROW1));
      wr.addr = s1_col_ff;
      wr.data = (s1_phase_ff == PH_ROW0) ? CSUM_W'(s1_pix_ff) : col_total;
   end

   // previous column totals shift on each row 2 word
   always_ff @(posedge clock) begin
      if (reset) begin
         tot_a_ff <= '0;
         tot_b_ff <= '0;
      end else if (s2_en && s1_v_ff && (s1_phase_ff == PH_ROW2)) begin
         tot_b_ff <= tot_a_ff;
         tot_a_ff <= col_total;
      end
   end

   // stage 2 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_sum_ff  <= win_sum;
         s2_pix_ff  <= s1_pix_ff;
         s2_hdr_ff  <= (s1_phase_ff == PH_HDR);
         s2_last_ff <= s1_last_ff;
      end
   end

   // divide by nine through the reciprocal
   assign prod = PROD_W'(s2_sum_ff) * PROD_W'(DIV_MUL);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_pixel_ff <= s2_hdr_ff ? s2_pix_ff : prod[DIV_SHIFT +: PIX_W];
         rsp_hdr_ff   <= s2_hdr_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_is_header = rsp_hdr_ff;
   assign rsp_last      = rsp_last_ff;

   // checks
   a_hdr_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HDR) |-> (col_ff <= HDR_END))
      else $error("header position past end of header");

   a_seg_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_ROW2) && (col_ff == ROW_END))
      |=> ((phase_ff == PH_HDR) && (col_ff == '0)))
      else $error("segment did not wrap to header byte 0");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !s2_hdr_ff) |-> (s2_sum_ff <= SUM_W'(MAX_SUM)))
      else $error("window sum out of range");

   a_last_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> !rsp_hdr_ff)
      else $error("last flag on a header word");

endmodule
